>>> sv/ypvm_pkg.sv
// Shared types, constants and the arctangent table for the view matrix core.
package ypvm_pkg;

  // Fixed-point widths.
  localparam int AngleW = 14;
  localparam int YawW   = 15;
  localparam int PosW   = 32;
  localparam int BasisW = 16;
  localparam int XyW    = 34;   // Q2.30 with headroom
  localparam int ZW     = 28;   // Q.24 angle with headroom
  localparam int AtanEntries = 24;

  // Constants of the angle reduction and the CORDIC start value.
  localparam logic signed [XyW-1:0]    CordicGain = XyW'(64'sd652032874);
  localparam logic signed [ZW-1:0]     PiQ24      = ZW'(64'sd52707179);
  localparam logic signed [ZW-1:0]     HalfPiQ24  = ZW'(64'sd26353589);
  localparam logic [YawW-1:0]          TwoPiQ12   = YawW'(25736);
  localparam logic signed [AngleW-1:0] PitchLimit = AngleW'(6144);
  localparam logic signed [17:0]       OneQ14     = 18'sd16384;

  typedef logic signed [BasisW-1:0] q14_t;
  typedef logic signed [PosW-1:0]   q16_t;

  typedef struct packed {
    q14_t x;
    q14_t y;
    q14_t z;
  } vec_t;

  typedef struct packed {
    q16_t x;
    q16_t y;
    q16_t z;
  } pos_t;

  // Arctangent of 2^-i in Q.24.
  function automatic logic signed [ZW-1:0] atan_q24(input int i);
    logic signed [ZW-1:0] r;
    unique case (i)
      0:  r = ZW'(13176795);
      1:  r = ZW'(7778716);
      2:  r = ZW'(4110060);
      3:  r = ZW'(2086331);
      4:  r = ZW'(1047214);
      5:  r = ZW'(524117);
      6:  r = ZW'(262123);
      7:  r = ZW'(131069);
      8:  r = ZW'(65536);
      9:  r = ZW'(32768);
      10: r = ZW'(16384);
      11: r = ZW'(8192);
      12: r = ZW'(4096);
      13: r = ZW'(2048);
      14: r = ZW'(1024);
      15: r = ZW'(512);
      16: r = ZW'(256);
      17: r = ZW'(128);
      18: r = ZW'(64);
      19: r = ZW'(32);
      20: r = ZW'(16);
      21: r = ZW'(8);
      22: r = ZW'(4);
      23: r = ZW'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/yaw_pitch_view_matrix_core.sv
// Top level: camera basis and view offsets from yaw, pitch and position.
//
//  channel | handshake      | fields
//  request | start / busy   | pitch_angle, yaw_angle, position_x/y/z
//  result  | done (strobe)  | right_*, up_*, forward_*, offset_*
//
// A request is taken in every cycle; busy stays low. Each result passes
// through one input stage, one stage per CORDIC step plus rounding, one
// multiply stage and three offset stages. Reset clears the valid bits only.
// The receiver cannot stall the results.
module yaw_pitch_view_matrix_core import ypvm_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [AngleW-1:0] pitch_angle,
  input  logic [YawW-1:0]          yaw_angle,
  input  q16_t                     position_x,
  input  q16_t                     position_y,
  input  q16_t                     position_z,
  output logic                     done,
  output q14_t                     right_x,
  output q14_t                     right_y,
  output q14_t                     right_z,
  output q14_t                     up_x,
  output q14_t                     up_y,
  output q14_t                     up_z,
  output q14_t                     forward_x,
  output q14_t                     forward_y,
  output q14_t                     forward_z,
  output q16_t                     offset_x,
  output q16_t                     offset_y,
  output q16_t                     offset_z
);

  localparam int N   = (CORDIC_ITERATIONS > AtanEntries) ? AtanEntries : CORDIC_ITERATIONS;
  localparam int Lat = N + 6;

  logic [Lat-1:0]        vld;
  logic signed [ZW-1:0]  pitch_z;
  logic signed [ZW-1:0]  yaw_z;
  logic                  s0_flip;
  logic signed [ZW-1:0]  pitch_z_next;
  logic signed [ZW-1:0]  yaw_z_next;
  logic                  flip_next;
  logic signed [AngleW-1:0] pitch_c;
  logic [YawW-1:0]       yaw_w;
  logic signed [ZW-1:0]  yaw_base;
  pos_t                  pos_d [N+3];
  logic                  flip_d [N+1];
  q14_t                  sp, cp, sy_raw, cy_raw, sy, cy;
  vec_t                  u, v, w;
  vec_t                  ud [3];
  vec_t                  vd [3];
  vec_t                  wd [3];

  assign busy = 1'b0;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Lat-2:0], start};
    end
  end
  assign done = vld[Lat-1];

  // Input stage: clamp the pitch and bring the yaw into the CORDIC range.
  always_comb begin
    if (pitch_angle > PitchLimit)       pitch_c = PitchLimit;
    else if (pitch_angle < -PitchLimit) pitch_c = -PitchLimit;
    else                                pitch_c = pitch_angle;
    pitch_z_next = ZW'(pitch_c) <<< 12;
    yaw_w = (yaw_angle >= TwoPiQ12) ? yaw_angle - TwoPiQ12 : yaw_angle;
    yaw_base = (ZW'(yaw_w) <<< 12) - PiQ24;
    flip_next = 1'b1;
    yaw_z_next = yaw_base;
    if (yaw_base > HalfPiQ24) begin
      yaw_z_next = yaw_base - PiQ24;
      flip_next = 1'b0;
    end else if (yaw_base < -HalfPiQ24) begin
      yaw_z_next = yaw_base + PiQ24;
      flip_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pitch_z  <= pitch_z_next;
    yaw_z    <= yaw_z_next;
    s0_flip  <= flip_next;
    pos_d[0] <= '{x: position_x, y: position_y, z: position_z};
  end

  // Side data waits alongside the CORDIC pipelines and the multiply stage.
  always_ff @(posedge clk) begin
    flip_d[0] <= s0_flip;
  end
  for (genvar i = 1; i < N + 3; i++) begin : g_pos
    always_ff @(posedge clk) pos_d[i] <= pos_d[i-1];
  end
  for (genvar i = 1; i < N + 1; i++) begin : g_flip
    always_ff @(posedge clk) flip_d[i] <= flip_d[i-1];
  end

  ypvm_cordic #(.ITER(N)) u_pitch (
    .clk(clk), .angle(pitch_z), .sin_val(sp), .cos_val(cp)
  );
  ypvm_cordic #(.ITER(N)) u_yaw (
    .clk(clk), .angle(yaw_z), .sin_val(sy_raw), .cos_val(cy_raw)
  );

  // A shift of pi flips the signs of the yaw sine and cosine.
  assign sy = flip_d[N] ? -sy_raw : sy_raw;
  assign cy = flip_d[N] ? -cy_raw : cy_raw;

  function automatic q14_t mul_q14(input q14_t a, input q14_t b);
    logic signed [31:0] p;
    p = (32'(a) * 32'(b) + 32'sd8192) >>> 14;
    return q14_t'(p);
  endfunction

  // Multiply stage: forward, right and up vectors.
  always_ff @(posedge clk) begin
    w <= '{x: mul_q14(cp, sy), y: -sp, z: mul_q14(cy, cp)};
    u <= '{x: -cy, y: '0, z: sy};
    v <= '{x: -mul_q14(sp, sy), y: -cp, z: -mul_q14(sp, cy)};
  end

  ypvm_offset u_offset (
    .clk(clk), .u(u), .v(v), .w(w), .pos(pos_d[N+2]),
    .off_x(offset_x), .off_y(offset_y), .off_z(offset_z)
  );

  // The basis waits for the offset pipeline.
  always_ff @(posedge clk) begin
    ud[0] <= u;  vd[0] <= v;  wd[0] <= w;
    ud[1] <= ud[0]; vd[1] <= vd[0]; wd[1] <= wd[0];
    ud[2] <= ud[1]; vd[2] <= vd[1]; wd[2] <= wd[1];
  end

  assign right_x   = ud[2].x;
  assign right_y   = ud[2].y;
  assign right_z   = ud[2].z;
  assign up_x      = vd[2].x;
  assign up_y      = vd[2].y;
  assign up_z      = vd[2].z;
  assign forward_x = wd[2].x;
  assign forward_y = wd[2].y;
  assign forward_z = wd[2].z;

endmodule

>>> sv/ypvm_cordic.sv
// Pipelined rotation-mode CORDIC giving rounded Q1.14 sine and cosine.
module ypvm_cordic import ypvm_pkg::*; #(
  parameter int ITER = 16
) (
  input  logic                 clk,
  input  logic signed [ZW-1:0] angle,
  output q14_t                 sin_val,
  output q14_t                 cos_val
);

  logic signed [XyW-1:0] x [ITER+1];
  logic signed [XyW-1:0] y [ITER+1];
  logic signed [ZW-1:0]  z [ITER+1];
  logic signed [17:0]    cos_rnd;
  logic signed [17:0]    sin_rnd;

  // The first step starts from the gain-corrected unit vector.
  assign x[0] = CordicGain;
  assign y[0] = '0;
  assign z[0] = angle;

  // One micro-rotation per register stage.
  for (genvar i = 0; i < ITER; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (z[i] >= 0) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - atan_q24(i);
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + atan_q24(i);
      end
    end
  end

  // Round Q2.30 to Q1.14 and clamp to plus or minus one.
  assign cos_rnd = 18'((x[ITER] + XyW'(32768)) >>> 16);
  assign sin_rnd = 18'((y[ITER] + XyW'(32768)) >>> 16);

  always_ff @(posedge clk) begin
    if (cos_rnd > OneQ14)       cos_val <= q14_t'(OneQ14);
    else if (cos_rnd < -OneQ14) cos_val <= q14_t'(-OneQ14);
    else                        cos_val <= q14_t'(cos_rnd);
    if (sin_rnd > OneQ14)       sin_val <= q14_t'(OneQ14);
    else if (sin_rnd < -OneQ14) sin_val <= q14_t'(-OneQ14);
    else                        sin_val <= q14_t'(sin_rnd);
  end

endmodule

>>> sv/ypvm_offset.sv
// Three-stage pipeline for the saturated view offsets, minus basis dot position.
module ypvm_offset import ypvm_pkg::*; (
  input  logic clk,
  input  vec_t u,
  input  vec_t v,
  input  vec_t w,
  input  pos_t pos,
  output q16_t off_x,
  output q16_t off_y,
  output q16_t off_z
);

  logic signed [47:0] prod [3][3];
  logic signed [49:0] sum  [3];
  vec_t               bas  [3];

  assign bas[0] = u;
  assign bas[1] = v;
  assign bas[2] = w;

  // Stage one: the nine basis by position products.
  for (genvar r = 0; r < 3; r++) begin : g_row
    always_ff @(posedge clk) begin
      prod[r][0] <= 48'(bas[r].x * pos.x);
      prod[r][1] <= 48'(bas[r].y * pos.y);
      prod[r][2] <= 48'(bas[r].z * pos.z);
    end

    // Stage two: the dot product.
    always_ff @(posedge clk) begin
      sum[r] <= 50'(prod[r][0]) + 50'(prod[r][1]) + 50'(prod[r][2]);
    end
  end

  // Stage three: negate, round to Q16.16 and saturate.
  function automatic q16_t round_sat(input logic signed [49:0] s);
    logic signed [50:0] n;
    logic signed [36:0] q;
    n = -51'(s) + 51'sd8192;
    q = 37'(n >>> 14);
    if (q > 37'sd2147483647)       return q16_t'(32'h7fff_ffff);
    else if (q < -37'sd2147483648) return q16_t'(32'h8000_0000);
    else                           return q16_t'(q);
  endfunction

  always_ff @(posedge clk) begin
    off_x <= round_sat(sum[0]);
    off_y <= round_sat(sum[1]);
    off_z <= round_sat(sum[2]);
  end

endmodule

>>> sv/ypvm_checker.sv
// Port-level checks for the view matrix core, bound to the top level.
module ypvm_checker import ypvm_pkg::*; #(
  parameter int LATENCY = 22
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input q14_t right_x,
  input q14_t right_y,
  input q14_t up_y
);

  // The core never refuses a request.
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  // Every request gives one result.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing");

  // No result appears without a request.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without request");

  // The right vector stays horizontal and its x component within plus or minus one.
  a_right_flat: assert property (@(posedge clk) disable iff (rst)
    done |-> (right_y == 0) && (right_x <= 16384) && (right_x >= -16384))
    else $error("right vector out of range");

  // Up y is minus the cosine of a pitch clamped to plus or minus 1.5 rad, so never positive.
  a_up_y: assert property (@(posedge clk) disable iff (rst)
    done |-> (up_y <= 0))
    else $error("up vector tilted over");

endmodule

bind yaw_pitch_view_matrix_core ypvm_checker #(.LATENCY(N + 6)) u_ypvm_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .right_x(right_x), .right_y(right_y), .up_y(up_y)
);

>>> verif/yaw_pitch_view_matrix_checker.sv
// Checker that predicts the camera basis and offsets and compares each result.
module yaw_pitch_view_matrix_checker import ypvm_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic signed [AngleW-1:0] pitch_angle,
  input  logic [YawW-1:0]          yaw_angle,
  input  q16_t                     position_x,
  input  q16_t                     position_y,
  input  q16_t                     position_z,
  input  logic                     done,
  input  q14_t                     right_x,
  input  q14_t                     right_y,
  input  q14_t                     right_z,
  input  q14_t                     up_x,
  input  q14_t                     up_y,
  input  q14_t                     up_z,
  input  q14_t                     forward_x,
  input  q14_t                     forward_y,
  input  q14_t                     forward_z,
  input  q16_t                     offset_x,
  input  q16_t                     offset_y,
  input  q16_t                     offset_z,
  output int                       fail_count,
  output int                       pending,
  output int                       view_count
);

  typedef struct packed {
    vec_t right;
    vec_t up;
    vec_t fwd;
    pos_t offset;
  } view_t;

  view_t expected_views[$];
  int    mismatches;

  // Arctangent of 2^-i in Q.24, kept here as an independent table.
  localparam longint AtanTable[24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Rotation-mode CORDIC; angle in Q.24, sine and cosine in Q1.14.
  function automatic void cordic_sin_cos(longint ang, output longint s, output longint c);
    longint x, y, dx, dy;
    int n;
    x = 652032874;
    y = 0;
    n = CORDIC_ITERATIONS > 24 ? 24 : CORDIC_ITERATIONS;
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (ang >= 0) begin
        x -= dx; y += dy; ang -= AtanTable[i];
      end else begin
        x += dx; y -= dy; ang += AtanTable[i];
      end
    end
    c = clamp((x + 32768) >>> 16, -16384, 16384);
    s = clamp((y + 32768) >>> 16, -16384, 16384);
  endfunction

  function automatic longint q14_mul(longint a, longint b);
    return (a * b + 8192) >>> 14;
  endfunction

  function automatic longint view_offset(longint b0, longint b1, longint b2,
                                         longint p0, longint p1, longint p2);
    longint acc;
    acc = -(b0 * p0 + b1 * p1 + b2 * p2);
    return clamp((acc + 8192) >>> 14, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic view_t predict_view(logic signed [AngleW-1:0] pa, logic [YawW-1:0] ya,
                                         q16_t px, q16_t py, q16_t pz);
    view_t  r;
    longint pitch, yaw, ang, sp, cp, sy, cy;
    longint wx, wy, wz, ux, uz, vx, vy, vz;
    bit     flip;
    pitch = clamp(longint'(pa), -6144, 6144);
    yaw = longint'(ya);
    if (yaw >= 25736) yaw -= 25736;
    cordic_sin_cos(pitch * 4096, sp, cp);
    // Shift yaw by pi, then fold into [-pi/2, pi/2]; each shift flips the signs.
    ang = yaw * 4096 - 52707179;
    flip = 1;
    if (ang > 26353589) begin
      ang -= 52707179; flip = !flip;
    end else if (ang < -26353589) begin
      ang += 52707179; flip = !flip;
    end
    cordic_sin_cos(ang, sy, cy);
    if (flip) begin
      sy = -sy; cy = -cy;
    end
    wx = q14_mul(cp, sy); wy = -sp; wz = q14_mul(cy, cp);
    ux = -cy; uz = sy;
    vx = -q14_mul(sp, sy); vy = -cp; vz = -q14_mul(sp, cy);
    r.right  = '{q14_t'(ux), q14_t'(0), q14_t'(uz)};
    r.up     = '{q14_t'(vx), q14_t'(vy), q14_t'(vz)};
    r.fwd    = '{q14_t'(wx), q14_t'(wy), q14_t'(wz)};
    r.offset.x = q16_t'(view_offset(ux, 0, uz, px, py, pz));
    r.offset.y = q16_t'(view_offset(vx, vy, vz, px, py, pz));
    r.offset.z = q16_t'(view_offset(wx, wy, wz, px, py, pz));
    return r;
  endfunction

  assign fail_count = mismatches;

  // Record each accepted request, then check each result against the oldest one.
  always @(posedge clk) begin
    view_t got, want;
    if (rst) begin
      mismatches <= 0;
      view_count <= 0;
    end else begin
      if (start && !busy)
        expected_views.push_back(predict_view(pitch_angle, yaw_angle,
                                              position_x, position_y, position_z));
      if (done) begin
        got.right  = '{right_x, right_y, right_z};
        got.up     = '{up_x, up_y, up_z};
        got.fwd    = '{forward_x, forward_y, forward_z};
        got.offset = '{offset_x, offset_y, offset_z};
        view_count <= view_count + 1;
        if (expected_views.size() == 0) begin
          if (mismatches < 10) $display("unexpected result at %0t", $time);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_views.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("mismatch at %0t", $time);
              $display("  right exp %0d %0d %0d got %0d %0d %0d", want.right.x,
                       want.right.y, want.right.z, got.right.x, got.right.y, got.right.z);
              $display("  up    exp %0d %0d %0d got %0d %0d %0d", want.up.x,
                       want.up.y, want.up.z, got.up.x, got.up.y, got.up.z);
              $display("  fwd   exp %0d %0d %0d got %0d %0d %0d", want.fwd.x,
                       want.fwd.y, want.fwd.z, got.fwd.x, got.fwd.y, got.fwd.z);
              $display("  off   exp %0d %0d %0d got %0d %0d %0d", want.offset.x,
                       want.offset.y, want.offset.z, got.offset.x, got.offset.y,
                       got.offset.z);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending <= expected_views.size();
  end

endmodule

>>> verif/yaw_pitch_view_matrix_core_tb.sv
// Testbench top: drives camera requests into the core and reports the verdict.
module yaw_pitch_view_matrix_core_tb import ypvm_pkg::*;;

  localparam int Iters = 16;
  localparam int Latency = Iters + 6;
  localparam int LimitCycles = 200000;

  logic clk, rst, start, busy, done;
  logic signed [AngleW-1:0] pitch_angle;
  logic [YawW-1:0] yaw_angle;
  q16_t position_x, position_y, position_z;
  q14_t right_x, right_y, right_z, up_x, up_y, up_z, forward_x, forward_y, forward_z;
  q16_t offset_x, offset_y, offset_z;
  int fail_count, pending, view_count, cycles, requests;

  yaw_pitch_view_matrix_core #(.CORDIC_ITERATIONS(Iters)) u_top (.*);

  yaw_pitch_view_matrix_checker #(.CORDIC_ITERATIONS(Iters)) u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("[yaw_pitch_view_matrix_core] ERROR");
      $finish;
    end
  end

  // Present one request at the falling edge and hold it until accepted.
  task automatic send_request(logic signed [AngleW-1:0] pa, logic [YawW-1:0] ya,
                              q16_t px, q16_t py, q16_t pz);
    pitch_angle <= pa; yaw_angle <= ya;
    position_x <= px; position_y <= py; position_z <= pz;
    start <= 1;
    do @(posedge clk); while (busy);
    requests++;
    @(negedge clk);
  endtask

  task automatic idle_burst();
    start <= 0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  function automatic q16_t rand_pos();
    case ($urandom_range(0, 3))
      0: return q16_t'($urandom_range(0, 2000)) - 1000;
      1: return $urandom() % 2 ? 32'sh7fffffff : 32'sh80000000;
      default: return q16_t'($urandom());
    endcase
  endfunction

  function automatic logic signed [AngleW-1:0] rand_pitch();
    // Mostly within range; sometimes anywhere, to hit the clamp.
    if ($urandom_range(0, 4) == 0) return AngleW'($urandom());
    return AngleW'(int'($urandom_range(0, 12288)) - 6144);
  endfunction

  initial begin
    logic signed [AngleW-1:0] pitches[8];
    logic [YawW-1:0] yaws[10];
    cycles = 0;
    requests = 0;
    rst = 1;
    start = 0;
    pitch_angle = 0; yaw_angle = 0;
    position_x = 0; position_y = 0; position_z = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: angle extremes, clamps, quadrant boundaries, position extremes.
    pitches = '{-14'sd6144, 14'sd6144, 14'sd0, 14'sh2000, 14'sd8191, 14'sd6145,
                -14'sd6145, 14'sd1};
    yaws = '{15'd0, 15'd25735, 15'd25736, 15'd32767, 15'd6434, 15'd6435,
             15'd12868, 15'd19302, 15'd19303, 15'd1};
    foreach (pitches[i])
      send_request(pitches[i], yaws[i], 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send_request(14'sd0, 15'd12868, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_request(-14'sd6144, 15'd6434, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    for (int i = 0; i < 10; i++)
      send_request(rand_pitch(), yaws[i], 0, 32'sd65536, -32'sd65536);

    // Hold off until every outstanding result has returned.
    start <= 0;
    while (pending != 0) @(negedge clk);

    // Random stream with idle bursts, then a back-to-back tail.
    for (int i = 0; i < 650; i++) begin
      if (i < 550 && $urandom_range(0, 3) == 0) idle_burst();
      send_request(rand_pitch(),
                   $urandom_range(0, 9) == 0 ? YawW'($urandom()) :
                                               YawW'($urandom_range(0, 25735)),
                   rand_pos(), rand_pos(), rand_pos());
    end
    start <= 0;

    while (pending != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
    $display("Sent %0d camera requests (clamped and wrapped angles, extreme positions);",
             requests);
    $display("checked %0d results, including back-to-back and gapped streams.", view_count);
    if (fail_count == 0) begin
      $display("[yaw_pitch_view_matrix_core] OK");
    end else begin
      $display("[yaw_pitch_view_matrix_core] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/ypvm_pkg.sv
sv/ypvm_cordic.sv
sv/ypvm_offset.sv
sv/yaw_pitch_view_matrix_core.sv
sv/ypvm_checker.sv
verif/yaw_pitch_view_matrix_checker.sv
verif/yaw_pitch_view_matrix_core_tb.sv
